// File: sv/iekfz_pkg.sv
// Shared types, constants and helper functions for the zero-velocity-aided inertial filter.
package iekfz_pkg;

    // Covariance fraction bits (Q16.F), usable from 24 to 40.
    localparam int COV_FRAC_BITS = 32;

    localparam int SW        = 48;          // state word width
    localparam int PW        = 2 * SW;      // full product width
    localparam int IN_W      = 312;         // packed input item
    localparam int OUT_W     = 192;         // packed result item
    localparam int AXES      = 3;
    localparam int MUL_STEPS = 3;           // 48x16 partial products per multiply
    localparam int DIV_STEPS = SW;          // one quotient bit per cycle
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int NUM_SRC   = 12;

    localparam logic [SW-1:0] COV_INIT =
        SW'(((64'd1 << COV_FRAC_BITS) + 64'd500) / 64'd1000);
    localparam int COV_LSH = (COV_FRAC_BITS >= 32) ? COV_FRAC_BITS - 32 : 0;
    localparam int COV_RSH = (COV_FRAC_BITS < 32) ? 32 - COV_FRAC_BITS : 1;

    localparam logic [31:0] GRAVITY_Q16 = 32'd642908;   // 9.81 in Q16.16

    localparam logic [31:0] GYRO_THR_RST  = 32'd65536;
    localparam logic [31:0] ACCEL_THR_RST = 32'd6554;
    localparam logic [31:0] PROC_NS_RST   = 32'd429497;
    localparam logic [31:0] MEAS_NS_RST   = 32'd42949673;

    localparam logic [1:0] CFG_GYRO_THR  = 2'd0;
    localparam logic [1:0] CFG_ACCEL_THR = 2'd1;
    localparam logic [1:0] CFG_PROC_NS   = 2'd2;
    localparam logic [1:0] CFG_MEAS_NS   = 2'd3;

    typedef logic [4:0] t_op;
    localparam t_op OP_DT2       = 5'd0;
    localparam t_op OP_STAT_LAST = 5'd5;
    localparam t_op OP_PRED_FIRST = 5'd6;
    localparam t_op OP_PRED_LAST = 5'd11;
    localparam t_op OP_UPD_FIRST = 5'd12;
    localparam t_op OP_UPD_LAST  = 5'd16;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_RND, ST_DIV_INIT, ST_DIV_STEP, ST_DIV_FIN, ST_DECIDE,
        ST_LOAD_AXIS, ST_PREDICT, ST_CHECK_S, ST_UPDATE, ST_STORE, ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        ACT_NONE, ACT_LOAD_IN, ACT_MUL, ACT_RND, ACT_DIV_INIT, ACT_DIV_STEP,
        ACT_DIV_FIN, ACT_DECIDE, ACT_LOAD_AXIS, ACT_PREDICT, ACT_CHECK_S,
        ACT_UPDATE, ACT_STORE, ACT_OUT
    } t_act;

    typedef enum logic [3:0] {
        SRC_DT, SRC_BX, SRC_BY, SRC_BZ, SRC_UP, SRC_LW, SRC_ACC, SRC_V,
        SRC_PV, SRC_VV, SRC_DT2, SRC_R
    } t_src;

    typedef enum logic [2:0] {
        DV_RAW, DV_S8, DV_S23, DV_S24, DV_S33, DV_S48, DV_S
    } t_div;

    typedef enum logic [3:0] {
        DS_DT2, DS_N2, DS_UPSQ, DS_LWSQ, DS_T0, DS_T1, DS_T2, DS_T3, DS_T4, DS_T5
    } t_dst;

    typedef struct packed {
        t_src a;
        t_src b;
        t_div dv;
        t_dst dst;
    } t_uop;

    typedef struct packed {
        t_act              act;
        t_op               op;
        logic [STEP_W-1:0] step;
        logic [1:0]        axis;
    } t_cmd;

    typedef struct packed {
        logic still;
        logic s_pos;
        logic out_free;
    } t_sts;

    // Micro-op program: stationary test, per-axis predict, per-axis update.
    function automatic t_uop uop_rom(input t_op op);
        t_uop u;
        case (op)
            5'd0:    u = '{SRC_DT,  SRC_DT,  DV_RAW, DS_DT2};
            5'd1:    u = '{SRC_BX,  SRC_BX,  DV_RAW, DS_N2};
            5'd2:    u = '{SRC_BY,  SRC_BY,  DV_RAW, DS_N2};
            5'd3:    u = '{SRC_BZ,  SRC_BZ,  DV_RAW, DS_N2};
            5'd4:    u = '{SRC_UP,  SRC_UP,  DV_RAW, DS_UPSQ};
            5'd5:    u = '{SRC_LW,  SRC_LW,  DV_RAW, DS_LWSQ};
            5'd6:    u = '{SRC_V,   SRC_DT,  DV_S24, DS_T0};
            5'd7:    u = '{SRC_ACC, SRC_DT2, DV_S33, DS_T1};
            5'd8:    u = '{SRC_ACC, SRC_DT,  DV_S8,  DS_T2};
            5'd9:    u = '{SRC_PV,  SRC_DT,  DV_S23, DS_T3};
            5'd10:   u = '{SRC_VV,  SRC_DT2, DV_S48, DS_T4};
            5'd11:   u = '{SRC_VV,  SRC_DT,  DV_S24, DS_T5};
            5'd12:   u = '{SRC_PV,  SRC_V,   DV_S,   DS_T0};
            5'd13:   u = '{SRC_V,   SRC_R,   DV_S,   DS_T1};
            5'd14:   u = '{SRC_PV,  SRC_PV,  DV_S,   DS_T2};
            5'd15:   u = '{SRC_PV,  SRC_R,   DV_S,   DS_T3};
            5'd16:   u = '{SRC_VV,  SRC_R,   DV_S,   DS_T4};
            default: u = '{SRC_DT,  SRC_DT,  DV_RAW, DS_T5};
        endcase
        return u;
    endfunction

    // Noise register (Q0.32) to covariance format.
    function automatic logic [SW-1:0] to_cov(input logic [31:0] v);
        logic [SW-1:0] x;
        x = SW'(v);
        if (COV_FRAC_BITS >= 32)
            return x << COV_LSH;
        else
            return (x + (SW'(1) << (COV_RSH - 1))) >> COV_RSH;
    endfunction

    function automatic logic [SW+3:0] ext52(input logic [SW-1:0] x);
        return {{4{x[SW-1]}}, x};
    endfunction

    function automatic logic [SW-1:0] sat48(input logic [SW+3:0] x);
        logic signed [SW+3:0] xs, hi_lim, lo_lim;
        xs     = x;
        hi_lim = {5'b00000, {(SW-1){1'b1}}};
        lo_lim = {5'b11111, {(SW-1){1'b0}}};
        if (xs > hi_lim)
            return {1'b0, {(SW-1){1'b1}}};
        else if (xs < lo_lim)
            return {1'b1, {(SW-1){1'b0}}};
        else
            return x[SW-1:0];
    endfunction

endpackage

// File: sv/inertial_ekf_zero_velocity_update.sv
// Top level of the zero-velocity-aided inertial Kalman filter.
//
// One IMU sample in, one estimate out. Each sample runs a per-axis
// position/velocity predict with a 2x2 covariance block per axis, a
// stationary test (gyro magnitudes and squared body-acceleration norm
// against 9.81) and, when stationary, a zero-velocity update. All products
// and quotients run through one shared 48x16 multiplier followed by a
// rounding shift or a restoring divider. A stationary sample adds five
// divides per axis. The input side takes a new sample only while the
// sequencer is idle, but a finished estimate waits in the output
// register, so the next sample can be taken before the previous result
// is picked up. Configuration writes are always taken (cfg_ready is tied
// high) and must only happen between samples. Outputs are the 48-bit
// Q16.32 state floored to Q16.16.
module inertial_ekf_zero_velocity_update (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // world_acc_x/y/z, body_acc_x/y/z, rate_x/y/z (32 each), time_step (24)
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [311:0] s_axis_tdata,
    // pos_x/y/z, vel_x/y/z (32 each)
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata,
    // stationary
    output logic         m_axis_tuser,
    // register writes: 0 gyro_threshold, 1 accel_threshold,
    // 2 process_noise, 3 measurement_noise
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import iekfz_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;   // write transfer

    iekfz_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    iekfz_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_still (m_axis_tuser)
    );

endmodule

// File: sv/iekfz_ctrl.sv
// Sequencer state machine: steps the micro-op program over the stationary test and three axes.
module iekfz_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  iekfz_pkg::t_sts i_sts,
    output iekfz_pkg::t_cmd o_cmd
);
    import iekfz_pkg::*;

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_axis, n_axis;
    t_uop              uop;
    t_state            adv_state;
    t_op               adv_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_DT2;
            r_step  <= '0;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_step  <= n_step;
            r_axis  <= n_axis;
        end
    end

    assign uop = uop_rom(r_op);

    // next step after a micro-op finishes
    always_comb begin
        adv_op = r_op;
        if (r_op == OP_STAT_LAST) begin
            adv_state = ST_DECIDE;
        end else if (r_op == OP_PRED_LAST) begin
            adv_state = ST_PREDICT;
        end else if (r_op == OP_UPD_LAST) begin
            adv_state = ST_UPDATE;
        end else begin
            adv_state = ST_MUL;
            adv_op    = r_op + 5'd1;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_step     = r_step;
        n_axis     = r_axis;
        o_in_ready = 1'b0;
        o_cmd.act  = ACT_NONE;
        o_cmd.op   = r_op;
        o_cmd.step = r_step;
        o_cmd.axis = r_axis;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.act = ACT_LOAD_IN;
                    n_op      = OP_DT2;
                    n_step    = '0;
                    n_state   = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.act = ACT_MUL;
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = (uop.dv == DV_S) ? ST_DIV_INIT : ST_RND;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_RND: begin
                o_cmd.act = ACT_RND;
                n_state   = adv_state;
                n_op      = adv_op;
            end
            ST_DIV_INIT: begin
                o_cmd.act = ACT_DIV_INIT;
                n_step    = '0;
                n_state   = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                o_cmd.act = ACT_DIV_STEP;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = ST_DIV_FIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DIV_FIN: begin
                o_cmd.act = ACT_DIV_FIN;
                n_state   = adv_state;
                n_op      = adv_op;
            end
            ST_DECIDE: begin
                o_cmd.act = ACT_DECIDE;
                n_axis    = '0;
                n_state   = ST_LOAD_AXIS;
            end
            ST_LOAD_AXIS: begin
                o_cmd.act = ACT_LOAD_AXIS;
                n_op      = OP_PRED_FIRST;
                n_state   = ST_MUL;
            end
            ST_PREDICT: begin
                o_cmd.act = ACT_PREDICT;
                n_state   = ST_CHECK_S;
            end
            ST_CHECK_S: begin
                o_cmd.act = ACT_CHECK_S;
                if (i_sts.still && i_sts.s_pos) begin
                    n_op    = OP_UPD_FIRST;
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_STORE;
                end
            end
            ST_UPDATE: begin
                o_cmd.act = ACT_UPDATE;
                n_state   = ST_STORE;
            end
            ST_STORE: begin
                o_cmd.act = ACT_STORE;
                if (r_axis == 2'(AXES - 1)) begin
                    n_state = ST_OUT;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = ST_LOAD_AXIS;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.act = ACT_OUT;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_MUL && r_op == OP_DT2 && r_step == '0))
        else $error("accepted item did not start the program");
    a_update_only_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && r_op >= OP_UPD_FIRST) |-> i_sts.still)
        else $error("update ops running on a moving sample");
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis != 2'd3)
        else $error("axis counter out of range");
    a_op_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_op <= OP_UPD_LAST))
        else $error("micro-op index out of range");

endmodule

// File: sv/iekfz_datapath.sv
// Datapath: config registers, filter state, shared multiplier, rounding and long divider.
module iekfz_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  iekfz_pkg::t_cmd             i_cmd,
    output iekfz_pkg::t_sts             o_sts,
    input  logic [iekfz_pkg::IN_W-1:0]  i_in_data,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [iekfz_pkg::OUT_W-1:0] o_out_data,
    output logic                        o_out_still
);
    import iekfz_pkg::*;

    // config
    logic [31:0] r_gthr, r_athr, r_qn, r_rn;
    // latched sample
    logic [31:0] r_wacc [AXES];
    logic [31:0] r_bacc [AXES];
    logic [31:0] r_rate [AXES];
    logic [23:0] r_dt;
    // stationary test
    logic [SW-1:0] r_dt2;
    logic [63:0]   r_n2, r_upsq, r_lwsq;
    logic          r_still;
    // arithmetic
    logic [PW-1:0] r_prod;
    logic [SW:0]   r_rem, r_s;
    logic [SW-1:0] r_numlo, r_quo;
    logic          r_dsat;
    logic [SW-1:0] r_t [6];
    // working copy of one axis
    logic [SW-1:0] r_wp, r_wv, r_wpp, r_wpv, r_wvv;
    // filter state
    logic [SW-1:0] r_pos [AXES];
    logic [SW-1:0] r_vel [AXES];
    logic [SW-1:0] r_cpp [AXES];
    logic [SW-1:0] r_cpv [AXES];
    logic [SW-1:0] r_cvv [AXES];
    // result
    logic             r_out_valid, r_out_still;
    logic [OUT_W-1:0] r_out_data;

    t_uop          uop;
    logic [SW-1:0] qcov, rcov;
    logic [32:0]   up33;
    logic [31:0]   lw;
    logic [SW:0]   src_val [NUM_SRC];
    logic [SW:0]   opa, opb, nega, negb;
    logic          a_neg, b_neg, p_neg;
    logic [SW-1:0] a_mag, b_mag, lim;
    logic [15:0]   chunk;
    logic [63:0]   partial;
    logic [PW-1:0] shifted;
    logic [5:0]    sh;
    logic [PW:0]   rnd_x, rnd_q;
    logic [SW-1:0] rnd_m, div_m, res_m, res_val;
    logic [PW:0]   num;
    logic [SW+1:0] trial;
    logic          trial_ge;
    logic [SW+1:0] s_full;
    logic          gyro_ok, up_fail, low_ok;
    logic [32:0]   rext [AXES];
    logic [32:0]   rmag [AXES];

    assign uop  = uop_rom(i_cmd.op);
    assign qcov = to_cov(r_qn);
    assign rcov = to_cov(r_rn);
    assign up33 = {1'b0, GRAVITY_Q16} + {1'b0, r_athr};
    assign lw   = GRAVITY_Q16 - r_athr;

    // operand sources, all as 49-bit signed
    always_comb begin
        src_val[SRC_DT]  = {25'b0, r_dt};
        src_val[SRC_BX]  = {{17{r_bacc[0][31]}}, r_bacc[0]};
        src_val[SRC_BY]  = {{17{r_bacc[1][31]}}, r_bacc[1]};
        src_val[SRC_BZ]  = {{17{r_bacc[2][31]}}, r_bacc[2]};
        src_val[SRC_UP]  = {17'b0, up33[31:0]};
        src_val[SRC_LW]  = {17'b0, lw};
        src_val[SRC_ACC] = {{17{r_wacc[i_cmd.axis][31]}}, r_wacc[i_cmd.axis]};
        src_val[SRC_V]   = {r_wv[SW-1], r_wv};
        src_val[SRC_PV]  = {r_wpv[SW-1], r_wpv};
        src_val[SRC_VV]  = {r_wvv[SW-1], r_wvv};
        src_val[SRC_DT2] = {1'b0, r_dt2};
        src_val[SRC_R]   = {1'b0, rcov};
    end

    assign opa   = src_val[uop.a];
    assign opb   = src_val[uop.b];
    assign nega  = -opa;
    assign negb  = -opb;
    assign a_neg = opa[SW];
    assign b_neg = opb[SW];
    assign a_mag = a_neg ? nega[SW-1:0] : opa[SW-1:0];
    assign b_mag = b_neg ? negb[SW-1:0] : opb[SW-1:0];
    assign p_neg = a_neg ^ b_neg;
    assign lim   = p_neg ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};

    // 48x16 partial product per cycle
    assign chunk   = b_mag[{i_cmd.step[1:0], 4'b0} +: 16];
    assign partial = {16'b0, a_mag} * {48'b0, chunk};
    assign shifted = {32'b0, partial} << {i_cmd.step[1:0], 4'b0};

    // power-of-two divide, round half away from zero
    always_comb begin
        case (uop.dv)
            DV_S8:   sh = 6'd8;
            DV_S23:  sh = 6'd23;
            DV_S24:  sh = 6'd24;
            DV_S33:  sh = 6'd33;
            DV_S48:  sh = 6'd48;
            default: sh = 6'd1;
        endcase
    end
    assign rnd_x = {1'b0, r_prod} + ((PW+1)'(1) << (sh - 6'd1));
    assign rnd_q = rnd_x >> sh;
    assign rnd_m = (rnd_q > {{(PW+1-SW){1'b0}}, lim}) ? lim : rnd_q[SW-1:0];
    assign div_m = (r_dsat || r_quo > lim) ? lim : r_quo;
    assign res_m = (i_cmd.act == ACT_DIV_FIN) ? div_m : rnd_m;
    assign res_val = p_neg ? -res_m : res_m;

    // long divide by S
    assign num      = {1'b0, r_prod} + {{(SW+1){1'b0}}, r_s[SW:1]};
    assign trial    = {r_rem, r_numlo[SW-1]};
    assign trial_ge = trial >= {1'b0, r_s};

    // stationary test
    always_comb begin
        gyro_ok = 1'b1;
        for (int i = 0; i < AXES; i++) begin
            rext[i] = {r_rate[i][31], r_rate[i]};
            rmag[i] = r_rate[i][31] ? -rext[i] : rext[i];
            if (rmag[i][31:0] >= r_gthr)
                gyro_ok = 1'b0;
        end
    end
    assign up_fail = !up33[32] && (r_n2 >= r_upsq);
    always_comb begin
        if (r_athr < GRAVITY_Q16)
            low_ok = r_n2 > r_lwsq;
        else if (r_athr == GRAVITY_Q16)
            low_ok = r_n2 != 64'd0;
        else
            low_ok = 1'b1;
    end

    assign s_full = {{2{r_wvv[SW-1]}}, r_wvv} + {2'b0, rcov};

    assign o_sts.still    = r_still;
    assign o_sts.s_pos    = !s_full[SW+1] && (s_full != '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gthr      <= GYRO_THR_RST;
            r_athr      <= ACCEL_THR_RST;
            r_qn        <= PROC_NS_RST;
            r_rn        <= MEAS_NS_RST;
            r_out_valid <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
                r_cpp[i] <= COV_INIT;
                r_cpv[i] <= '0;
                r_cvv[i] <= COV_INIT;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GYRO_THR:  r_gthr <= i_cfg_data;
                    CFG_ACCEL_THR: r_athr <= i_cfg_data;
                    CFG_PROC_NS:   r_qn   <= i_cfg_data;
                    CFG_MEAS_NS:   r_rn   <= i_cfg_data;
                    default:       r_gthr <= r_gthr;
                endcase
            end
            if (i_cmd.act == ACT_STORE) begin
                r_pos[i_cmd.axis] <= r_wp;
                r_vel[i_cmd.axis] <= r_wv;
                r_cpp[i_cmd.axis] <= r_wpp;
                r_cpv[i_cmd.axis] <= r_wpv;
                r_cvv[i_cmd.axis] <= r_wvv;
            end
            if (i_cmd.act == ACT_OUT)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.act)
            ACT_LOAD_IN: begin
                for (int i = 0; i < AXES; i++) begin
                    r_wacc[i] <= i_in_data[32*i +: 32];
                    r_bacc[i] <= i_in_data[96 + 32*i +: 32];
                    r_rate[i] <= i_in_data[192 + 32*i +: 32];
                end
                r_dt <= i_in_data[311:288];
                r_n2 <= '0;
            end
            ACT_MUL: begin
                r_prod <= ((i_cmd.step[1:0] == 2'd0) ? '0 : r_prod) + shifted;
            end
            ACT_RND, ACT_DIV_FIN: begin
                case (uop.dst)
                    DS_DT2:  r_dt2  <= r_prod[SW-1:0];
                    DS_N2:   r_n2   <= r_n2 + r_prod[63:0];
                    DS_UPSQ: r_upsq <= r_prod[63:0];
                    DS_LWSQ: r_lwsq <= r_prod[63:0];
                    DS_T0:   r_t[0] <= res_val;
                    DS_T1:   r_t[1] <= res_val;
                    DS_T2:   r_t[2] <= res_val;
                    DS_T3:   r_t[3] <= res_val;
                    DS_T4:   r_t[4] <= res_val;
                    default: r_t[5] <= res_val;
                endcase
            end
            ACT_DIV_INIT: begin
                // quotient would need more than 48 bits: saturate
                r_dsat  <= num[PW:SW] >= r_s;
                r_rem   <= num[PW:SW];
                r_numlo <= num[SW-1:0];
                r_quo   <= '0;
            end
            ACT_DIV_STEP: begin
                r_rem   <= trial_ge ? (SW+1)'(trial - {1'b0, r_s}) : trial[SW:0];
                r_numlo <= {r_numlo[SW-2:0], 1'b0};
                r_quo   <= {r_quo[SW-2:0], trial_ge};
            end
            ACT_DECIDE: begin
                r_still <= gyro_ok && !up_fail && low_ok;
            end
            ACT_LOAD_AXIS: begin
                r_wp  <= r_pos[i_cmd.axis];
                r_wv  <= r_vel[i_cmd.axis];
                r_wpp <= r_cpp[i_cmd.axis];
                r_wpv <= r_cpv[i_cmd.axis];
                r_wvv <= r_cvv[i_cmd.axis];
            end
            ACT_PREDICT: begin
                r_wp  <= sat48(ext52(r_wp) + ext52(r_t[0]) + ext52(r_t[1]));
                r_wv  <= sat48(ext52(r_wv) + ext52(r_t[2]));
                r_wpp <= sat48(ext52(r_wpp) + ext52(r_t[3]) + ext52(r_t[4])
                               + {4'b0, qcov});
                r_wpv <= sat48(ext52(r_wpv) + ext52(r_t[5]));
                r_wvv <= sat48(ext52(r_wvv) + {4'b0, qcov});
            end
            ACT_CHECK_S: begin
                r_s <= s_full[SW:0];
            end
            ACT_UPDATE: begin
                r_wp  <= sat48(ext52(r_wp) - ext52(r_t[0]));
                r_wv  <= r_t[1];
                r_wpp <= sat48(ext52(r_wpp) - ext52(r_t[2]));
                r_wpv <= r_t[3];
                r_wvv <= r_t[4];
            end
            ACT_OUT: begin
                r_out_data <= {r_vel[2][SW-1:16], r_vel[1][SW-1:16], r_vel[0][SW-1:16],
                               r_pos[2][SW-1:16], r_pos[1][SW-1:16], r_pos[0][SW-1:16]};
                r_out_still <= r_still;
            end
            default: begin
                r_dt <= r_dt;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_still = r_out_still;

endmodule

// File: tb/iekfz_estimate_checker.sv
// Watches the sample, estimate and register channels, predicts each estimate and compares.
`timescale 1ns / 1ps

module iekfz_estimate_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [311:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [191:0] i_m_tdata,
    input  logic         i_m_tuser,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_estimates,
    output int           o_still_count
);
    import iekfz_pkg::*;

    typedef logic signed [47:0] t_word;

    typedef struct {
        logic [31:0] pos [3];
        logic [31:0] vel [3];
        logic        still;
    } t_estimate;

    localparam t_word WORD_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam t_word WORD_MIN = -48'sh8000_0000_0000;

    // local copy of the filter state and registers
    logic [31:0] gyro_thr, accel_thr, proc_ns, meas_ns;
    t_word       pos_st [3], vel_st [3], ppp [3], ppv [3], pvv [3];
    t_estimate   expected_q [$];

    // operands are 49-bit signed so that dt*dt stays positive
    function automatic t_word rnd_mul_div(input logic signed [48:0] a,
                                          input logic signed [48:0] b,
                                          input logic [63:0] c);
        logic [127:0]       x, y, q;
        logic [47:0]        lim;
        logic               neg;
        neg = (a < 0) != (b < 0);
        x   = (a < 0) ? 128'(-a) : 128'(a);
        y   = (b < 0) ? 128'(-b) : 128'(b);
        q   = (x * y + 128'(c >> 1)) / 128'(c);
        lim = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        if (q > 128'(lim))
            q = 128'(lim);
        return neg ? t_word'(-q[47:0]) : t_word'(q[47:0]);
    endfunction

    function automatic t_word clamp_word(input logic signed [53:0] x);
        if (x > 54'(WORD_MAX))
            return WORD_MAX;
        if (x < 54'(WORD_MIN))
            return WORD_MIN;
        return x[47:0];
    endfunction

    function automatic t_word noise_to_cov(input logic [31:0] v);
        logic [63:0] x;
        x = 64'(v);
        if (COV_FRAC_BITS >= 32)
            return t_word'(x << (COV_FRAC_BITS - 32));
        return t_word'((x + (64'd1 << (31 - COV_FRAC_BITS))) >> (32 - COV_FRAC_BITS));
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? 32'(-$signed({1'b1, v})) : v;
    endfunction

    // gyro below limit on every axis and squared norm inside the gravity band
    function automatic logic is_still(input logic [311:0] d);
        logic [63:0] n2, up, lw, m;
        n2 = '0;
        for (int i = 0; i < 3; i++) begin
            if (mag32(d[32*(6+i) +: 32]) >= gyro_thr)
                return 1'b0;
            m  = 64'(mag32(d[32*(3+i) +: 32]));
            n2 = n2 + m * m;
        end
        up = 64'(GRAVITY_Q16) + 64'(accel_thr);
        if (up < 64'h1_0000_0000 && n2 >= up * up)
            return 1'b0;
        if (accel_thr < GRAVITY_Q16) begin
            lw = 64'(GRAVITY_Q16 - accel_thr);
            return n2 > lw * lw;
        end
        if (accel_thr == GRAVITY_Q16)
            return n2 != 0;
        return 1'b1;
    endfunction

    function automatic t_estimate advance_filter(input logic [311:0] d);
        t_estimate          e;
        t_word              a, p, v, pp, pv, vv, q, r;
        logic signed [48:0] dt, dt2;
        logic signed [63:0] s;
        t_word              np, nv, npp, npv, nvv;
        dt      = 49'(d[311:288]);
        dt2     = dt * dt;
        q       = noise_to_cov(proc_ns);
        r       = noise_to_cov(meas_ns);
        e.still = is_still(d);
        for (int i = 0; i < 3; i++) begin
            a  = t_word'($signed(d[32*i +: 32]));
            p  = pos_st[i];
            v  = vel_st[i];
            pp = ppp[i];
            pv = ppv[i];
            vv = pvv[i];
            p  = clamp_word(54'(p) + 54'(rnd_mul_div(49'(v), dt, 64'd1 << 24))
                            + 54'(rnd_mul_div(49'(a), dt2, 64'd1 << 33)));
            v  = clamp_word(54'(v) + 54'(rnd_mul_div(49'(a), dt, 64'd1 << 8)));
            pp = clamp_word(54'(pp) + 54'(rnd_mul_div(49'(pv), dt, 64'd1 << 23))
                            + 54'(rnd_mul_div(49'(vv), dt2, 64'd1 << 48)) + 54'(q));
            pv = clamp_word(54'(pv) + 54'(rnd_mul_div(49'(vv), dt, 64'd1 << 24)));
            vv = clamp_word(54'(vv) + 54'(q));
            if (e.still) begin
                s = 64'(vv) + 64'(r);
                // zero innovation variance: the axis keeps its predicted values
                if (s > 0) begin
                    np  = clamp_word(54'(p) - 54'(rnd_mul_div(49'(pv), 49'(v), s)));
                    nv  = rnd_mul_div(49'(v), 49'(r), s);
                    npp = clamp_word(54'(pp) - 54'(rnd_mul_div(49'(pv), 49'(pv), s)));
                    npv = rnd_mul_div(49'(pv), 49'(r), s);
                    nvv = rnd_mul_div(49'(vv), 49'(r), s);
                    p = np; v = nv; pp = npp; pv = npv; vv = nvv;
                end
            end
            pos_st[i] = p;
            vel_st[i] = v;
            ppp[i]    = pp;
            ppv[i]    = pv;
            pvv[i]    = vv;
            e.pos[i]  = p[47:16];
            e.vel[i]  = v[47:16];
        end
        return e;
    endfunction

    always @(posedge i_clk) begin
        t_estimate e;
        logic [31:0] got;
        int          errs;
        errs = 0;
        if (!i_rst_n) begin
            gyro_thr  <= GYRO_THR_RST;
            accel_thr <= ACCEL_THR_RST;
            proc_ns   <= PROC_NS_RST;
            meas_ns   <= MEAS_NS_RST;
            for (int i = 0; i < 3; i++) begin
                pos_st[i] = '0;
                vel_st[i] = '0;
                ppp[i]    = t_word'(COV_INIT);
                ppv[i]    = '0;
                pvv[i]    = t_word'(COV_INIT);
            end
            expected_q.delete();
            o_fail_count  <= 0;
            o_estimates   <= 0;
            o_still_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GYRO_THR:  gyro_thr  <= i_cfg_data;
                    CFG_ACCEL_THR: accel_thr <= i_cfg_data;
                    CFG_PROC_NS:   proc_ns   <= i_cfg_data;
                    CFG_MEAS_NS:   meas_ns   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                expected_q.push_back(advance_filter(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                o_estimates <= o_estimates + 1;
                if (expected_q.size() == 0) begin
                    $error("estimate with none expected: %h", i_m_tdata);
                    errs++;
                end else begin
                    e = expected_q.pop_front();
                    if (e.still)
                        o_still_count <= o_still_count + 1;
                    for (int i = 0; i < 6; i++) begin
                        got = i_m_tdata[32*i +: 32];
                        if (got !== (i < 3 ? e.pos[i] : e.vel[i-3])) begin
                            $error("%s_%s: expected %h, got %h", i < 3 ? "pos" : "vel",
                                   (i % 3 == 0) ? "x" : (i % 3 == 1) ? "y" : "z",
                                   i < 3 ? e.pos[i] : e.vel[i-3], got);
                            errs++;
                        end
                    end
                    if (i_m_tuser !== e.still) begin
                        $error("stationary: expected %b, got %b", e.still, i_m_tuser);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                o_fail_count <= o_fail_count + errs;
        end
        o_pending <= expected_q.size();
    end

endmodule

// File: tb/inertial_ekf_zero_velocity_update_tb.sv
// Stimulus and verdict for the zero-velocity-aided inertial filter.
`timescale 1ns / 1ps

module inertial_ekf_zero_velocity_update_tb;
    import iekfz_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [311:0] s_axis_tdata;   // world_acc x/y/z, body_acc x/y/z, rate x/y/z, time_step
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;   // pos x/y/z, vel x/y/z
    logic         m_axis_tuser;   // stationary
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    int fail_count, pending, estimates, still_count;
    int samples_sent;
    int send_idle_pct, recv_stall_pct;   // idling odds of the current phase
    logic hold_req, hold_taken;
    int   hold_left;
    logic [31:0] gyro_cur;                // gyro limit in force, to aim rates below it

    inertial_ekf_zero_velocity_update u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    iekfz_estimate_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_estimates   (estimates),
        .o_still_count (still_count)
    );

    // starts low so the first rising edge comes with reset already driven
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Receiver: random stalls per phase; one long hold-off on request so the
    // block fills up and stops taking samples.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_taken    <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken    <= 1'b1;
            hold_left     <= 4000;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        #60ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [311:0] pack_sample(
        input logic [31:0] wx, wy, wz, bx, by, bz, rx, ry, rz, input logic [23:0] dt);
        return {dt, rz, ry, rx, bz, by, bx, wz, wy, wx};
    endfunction

    function automatic logic [31:0] small_signed(input int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // Mostly samples near rest (so the update runs), some motion, some raw noise.
    function automatic logic [311:0] random_sample();
        int          kind;
        logic [31:0] rl;
        logic [31:0] w [3], b [3], g [3];
        logic [23:0] dt;
        kind = $urandom_range(0, 99);
        rl   = (gyro_cur > 32'd2) ? gyro_cur - 32'd1 : 32'd1;
        if (rl > 32'h7FFF_FFFF)
            rl = 32'h7FFF_FFFF;
        dt = 24'($urandom_range(83886, 251658));
        for (int i = 0; i < 3; i++) begin
            w[i] = small_signed(131072);
            b[i] = small_signed(3000);
            g[i] = (kind < 70) ? 32'($signed($urandom_range(0, 2 * (rl >> 1))) -
                                     $signed(rl >> 1))
                               : small_signed(500000);
        end
        b[2] = b[2] + GRAVITY_Q16;
        if (kind >= 85) begin
            for (int i = 0; i < 3; i++) begin
                w[i] = $urandom;
                b[i] = $urandom;
                g[i] = $urandom;
            end
            dt = 24'($urandom);
        end
        return pack_sample(w[0], w[1], w[2], b[0], b[1], b[2], g[0], g[1], g[2], dt);
    endfunction

    task automatic send_sample(input logic [311:0] d);
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        samples_sent++;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Writes all four registers back to back; only called with the block idle.
    task automatic write_regs(input logic [31:0] gyro, accel, proc, meas);
        logic [31:0] vals [4];
        vals = '{gyro, accel, proc, meas};
        for (int i = 0; i < 4; i++) begin
            i_cfg_index <= 2'(i);
            i_cfg_data  <= vals[i];
            i_cfg_valid <= 1'b1;
            do @(negedge i_clk); while (!o_cfg_ready);
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        gyro_cur = gyro;
    endtask

    task automatic drain_estimates();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
        endcase
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_GYRO_THR;
        i_cfg_data    = '0;
        hold_req      = 1'b0;
        samples_sent  = 0;
        gyro_cur      = GYRO_THR_RST;
        set_idling(0);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset registers: rest, gyro limit edges, norm band edges.
        send_sample(pack_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 24'd0));
        send_sample(pack_sample(0, 0, 0, 0, 0, GRAVITY_Q16, 0, 0, 0, 24'd167772));
        send_sample(pack_sample(0, 0, 0, 0, 0, GRAVITY_Q16, 32'd65536, 0, 0, 24'd167772));
        send_sample(pack_sample(0, 0, 0, 0, 0, GRAVITY_Q16, 0, -32'sd65535, 0, 24'd167772));
        send_sample(pack_sample(1, 2, 3, 0, 0, GRAVITY_Q16 + 6554, 0, 0, 0, 24'd1));
        send_sample(pack_sample(1, 2, 3, 0, 0, GRAVITY_Q16 + 6553, 0, 0, 0, 24'd1));
        send_sample(pack_sample(5, 0, 0, 0, 0, GRAVITY_Q16 - 6554, 0, 0, 0, 24'd100));
        send_sample(pack_sample(5, 0, 0, 0, 0, -(GRAVITY_Q16 - 6553), 0, 0, 0, 24'd100));
        send_sample({24'hFF_FFFF, {9{32'h7FFF_FFFF}}});
        send_sample({24'hFF_FFFF, {9{32'h8000_0000}}});
        // drive position and velocity into saturation both ways
        repeat (3) send_sample(pack_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                           0, 0, GRAVITY_Q16, 0, 0, 0, 24'hFF_FFFF));
        repeat (3) send_sample(pack_sample(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                           0, 0, GRAVITY_Q16, 0, 0, 0, 24'hFF_FFFF));
        send_sample({24'hAA_AAAA, {9{32'hAAAA_AAAA}}});
        send_sample({24'h55_5555, {9{32'h5555_5555}}});
        drain_estimates();

        // Limit exactly at gravity, then just above: zero norm behaves differently.
        write_regs(GYRO_THR_RST, GRAVITY_Q16, PROC_NS_RST, MEAS_NS_RST);
        send_sample(pack_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 24'd1000));
        send_sample(pack_sample(0, 0, 0, 0, 0, 1, 0, 0, 0, 24'd1000));
        drain_estimates();
        write_regs(GYRO_THR_RST, GRAVITY_Q16 + 1, PROC_NS_RST, MEAS_NS_RST);
        send_sample(pack_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 24'd1000));
        drain_estimates();

        // Never stationary; noise registers at maximum.
        write_regs(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_idling(1);
        repeat (40) send_sample(random_sample());
        drain_estimates();

        // Always stationary with zero noise: velocity variance collapses and the
        // innovation variance then hits zero.
        write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
        set_idling(2);
        repeat (40) send_sample(random_sample());
        drain_estimates();

        // Realistic settings, all idling modes, one long receiver hold-off and
        // one pause until the block has emptied.
        for (int ph = 0; ph < 8; ph++) begin
            write_regs(32'($urandom_range(16384, 1048576)), 32'($urandom_range(0, 65536)),
                       (ph == 7) ? 32'd1 : $urandom_range(0, 4294967),
                       (ph == 7) ? 32'd1 : $urandom);
            set_idling(ph);
            for (int k = 0; k < 120; k++) begin
                if (ph == 3 && k == 10)
                    hold_req = 1'b1;
                if (ph == 5 && k == 60)
                    drain_estimates();
                send_sample(random_sample());
            end
            drain_estimates();
        end

        repeat (1000) @(posedge i_clk);
        $display("Covered %0d samples (%0d stationary) over 13 register settings,",
                 samples_sent, still_count);
        $display("  threshold edges, saturation, zero innovation variance, stalls and a hold-off.");
        if (fail_count == 0 && estimates == samples_sent)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
sv/iekfz_pkg.sv
sv/iekfz_ctrl.sv
sv/iekfz_datapath.sv
sv/inertial_ekf_zero_velocity_update.sv
tb/iekfz_estimate_checker.sv
tb/inertial_ekf_zero_velocity_update_tb.sv
